// ===== hw/rtl/crsf_pkg.sv =====
// ----------------------------------------------------------------------------
// crsf_pkg: shared types and constants of the substring find unit
// Item layouts, register indexes, find modes and field widths.
// ----------------------------------------------------------------------------
package crsf_pkg;

  localparam int OFFSET_BITS   = 20;
  localparam int COUNT_W       = OFFSET_BITS + 1;
  localparam int LEN_W         = 5;
  localparam int MODE_W        = 2;
  localparam int PATTERN_BYTES = 16;
  localparam int PATTERN_IDX_W = $clog2(PATTERN_BYTES);
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CURSOR       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FIND_MODE    = 3'd4;

  // find modes; the unused code behaves as normal
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PREV   = 2'd2;

  typedef logic [PATTERN_BYTES-1:0][7:0] pattern_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [COUNT_W-1:0]     occurrence_count;
    logic [OFFSET_BITS-1:0] chosen_index;
    logic [OFFSET_BITS-1:0] chosen_offset;
    logic [LEN_W-1:0]       chosen_length;
  } out_item_t;

endpackage

// ===== hw/rtl/crsf_window_match.sv =====
// ----------------------------------------------------------------------------
// crsf_window_match: parallel compare of the byte window with the pattern
// Newest byte sits in entry 0; the oldest of the last length bytes meets
// pattern byte 0.
// ----------------------------------------------------------------------------
module crsf_window_match import crsf_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
  input  pattern_t                          pattern,
  input  logic [LEN_W-1:0]                  length,
  output logic                              hit
);

  always_comb begin
    logic [LEN_W-1:0] k;
    logic [7:0]       pb;
    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      k  = LEN_W'(int'(length) - 1 - i);
      // bytes past the pattern registers read as zero
      pb = (k < LEN_W'(PATTERN_BYTES)) ? pattern[k[PATTERN_IDX_W-1:0]] : 8'd0;
      if ((i < int'(length)) && (window[i] != pb)) begin
        hit = 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/cursor_relative_substring_find_unit.sv =====
// ----------------------------------------------------------------------------
// cursor_relative_substring_find_unit: streaming pattern search
// Scans a text byte stream for non-overlapping pattern matches, counts them
// and reports one match chosen relative to a cursor when the text ends.
// ----------------------------------------------------------------------------
//
//  channel | signals                           | moves
//  --------+-----------------------------------+-------------------------------
//  config  | cfg_write, cfg_index, cfg_data    | register write, no wait
//  in      | in_valid, in_ready, in_item       | one text byte per item
//  out     | out_valid, out_ready, out_item    | one result per text (last byte)
//
//  One item per cycle sustained. A byte is shifted into the window register
//  on acceptance; the compare stage then compares it, updates the match
//  statistics and, on the last byte, loads the result register and raises
//  out_valid. The compare stage stalls only when it holds a last byte and
//  the result register is still occupied. Synchronous reset clears the
//  valid flags, the window, the match statistics and the configuration
//  registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cursor_relative_substring_find_unit import crsf_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item
);

  // ---- configuration registers ----
  logic [63:0]            pattern_low;
  logic [63:0]            pattern_high;
  logic [LEN_W-1:0]       pattern_length;
  logic [OFFSET_BITS-1:0] cursor_position;
  logic [MODE_W-1:0]      find_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low     <= '0;
      pattern_high    <= '0;
      pattern_length  <= '0;
      cursor_position <= '0;
      find_mode       <= MODE_NORMAL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low     <= cfg_data;
        REG_PATTERN_HIGH: pattern_high    <= cfg_data;
        REG_PATTERN_LEN:  pattern_length  <= cfg_data[LEN_W-1:0];
        REG_CURSOR:       cursor_position <= cfg_data[OFFSET_BITS-1:0];
        REG_FIND_MODE:    find_mode       <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- handshake ----
  // Only a last byte needs the result register, so only it can stall.
  logic s1_valid, s1_last, s1_scan;
  logic [OFFSET_BITS-1:0] s1_pos;
  logic out_free, s2_adv, in_fire, stream_clear;

  assign out_free     = !out_valid || out_ready;
  assign s2_adv       = s1_valid && (!s1_last || out_free);
  assign in_ready     = !s1_valid || s2_adv;
  assign in_fire      = in_valid && in_ready;
  assign stream_clear = s2_adv && s1_last;

  // ---- stage 1: window and text position ----
  logic [MAX_PATTERN_BYTES-1:0][7:0] window, win_base, window_next;
  logic [OFFSET_BITS-1:0]            text_position, pos_base, text_position_next;
  logic                              text_full, full_base, text_full_next;

  always_comb begin
    // a finishing text hands a clean stream to the byte arriving alongside it
    win_base           = stream_clear ? '0 : window;
    pos_base           = stream_clear ? '0 : text_position;
    full_base          = stream_clear ? 1'b0 : text_full;
    window_next        = win_base;
    text_position_next = pos_base;
    text_full_next     = full_base;
    if (in_fire && !full_base) begin
      for (int i = MAX_PATTERN_BYTES - 1; i >= 1; i--) begin
        window_next[i] = win_base[i-1];
      end
      window_next[0] = in_item.text_byte;
      if (pos_base == OFF_MAX) begin
        text_full_next = 1'b1;
      end else begin
        text_position_next = pos_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      text_position <= '0;
      text_full     <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      window        <= window_next;
      text_position <= text_position_next;
      text_full     <= text_full_next;
      if (in_ready) begin
        s1_valid <= in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last <= in_item.last_byte;
      s1_scan <= !full_base;   // bytes past the offset range are only consumed
      s1_pos  <= pos_base;
    end
  end

  // ---- stage 2: compare and match statistics ----
  logic     hit;
  pattern_t pattern;

  assign pattern = {pattern_high, pattern_low};

  crsf_window_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_match (
    .window (window),
    .pattern(pattern),
    .length (pattern_length),
    .hit    (hit)
  );

  logic [COUNT_W-1:0]     next_allowed_start, nas_next;
  logic [COUNT_W-1:0]     match_count, count_next;
  logic [OFFSET_BITS-1:0] first_off, first_next;
  logic [OFFSET_BITS-1:0] last_off, last_next;
  logic [OFFSET_BITS-1:0] before_off, before_next;
  logic [OFFSET_BITS-1:0] cur_index, cur_index_next;
  logic [OFFSET_BITS-1:0] cur_off, cur_off_next;
  logic                   cur_seen, cur_seen_next;
  logic [OFFSET_BITS-1:0] after_off, after_next;
  logic                   after_seen, after_seen_next;

  logic [COUNT_W-1:0]     pos_inc, start_w;
  logic [OFFSET_BITS-1:0] start;
  logic                   len_ok, take;

  assign len_ok  = (pattern_length != '0) && (int'(pattern_length) <= MAX_PATTERN_BYTES);
  assign pos_inc = {1'b0, s1_pos} + 1'b1;
  assign start_w = pos_inc - COUNT_W'(pattern_length);
  assign start   = start_w[OFFSET_BITS-1:0];
  assign take    = s1_scan && len_ok && (pos_inc >= COUNT_W'(pattern_length)) &&
                   (start_w >= next_allowed_start) && hit;

  always_comb begin
    nas_next        = next_allowed_start;
    count_next      = match_count;
    first_next      = first_off;
    last_next       = last_off;
    before_next     = before_off;
    cur_index_next  = cur_index;
    cur_off_next    = cur_off;
    cur_seen_next   = cur_seen;
    after_next      = after_off;
    after_seen_next = after_seen;
    if (take) begin
      if (match_count == '0) begin
        first_next = start;
      end
      last_next = start;
      if (cur_seen) begin
        if (!after_seen) begin
          after_next      = start;
          after_seen_next = 1'b1;
        end
      end else if (start >= cursor_position) begin
        // count never passes the number of offsets, so it fits an index here
        cur_index_next = match_count[OFFSET_BITS-1:0];
        cur_off_next   = start;
        cur_seen_next  = 1'b1;
      end else begin
        before_next = start;
      end
      if (match_count <= {1'b0, OFF_MAX}) begin
        count_next = match_count + 1'b1;
      end
      nas_next = start_w + COUNT_W'(pattern_length);
    end
  end

  // ---- result choice, from the statistics including this byte ----
  out_item_t              result;
  logic [OFFSET_BITS-1:0] c_idx, c_off;

  always_comb begin
    c_idx  = cur_seen_next ? cur_index_next : '0;
    c_off  = cur_seen_next ? cur_off_next : first_next;
    result = '0;
    if (count_next != '0) begin
      result.found            = 1'b1;
      result.occurrence_count = count_next;
      result.chosen_index     = c_idx;
      result.chosen_offset    = c_off;
      result.chosen_length    = pattern_length;
      if (find_mode == MODE_PREV) begin
        if (c_idx == '0) begin
          // wrap back to the final match
          result.chosen_index  = OFFSET_BITS'(count_next - 1'b1);
          result.chosen_offset = last_next;
        end else begin
          result.chosen_index  = c_idx - 1'b1;
          result.chosen_offset = before_next;
        end
      end else if ((find_mode == MODE_NEXT) && cur_seen_next &&
                   (cursor_position == cur_off_next)) begin
        if (after_seen_next) begin
          result.chosen_index  = c_idx + 1'b1;
          result.chosen_offset = after_next;
        end else begin
          result.chosen_index  = '0;
          result.chosen_offset = first_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || stream_clear) begin
      next_allowed_start <= '0;
      match_count        <= '0;
      first_off          <= '0;
      last_off           <= '0;
      before_off         <= '0;
      cur_index          <= '0;
      cur_off            <= '0;
      cur_seen           <= 1'b0;
      after_off          <= '0;
      after_seen         <= 1'b0;
    end else if (s2_adv) begin
      next_allowed_start <= nas_next;
      match_count        <= count_next;
      first_off          <= first_next;
      last_off           <= last_next;
      before_off         <= before_next;
      cur_index          <= cur_index_next;
      cur_off            <= cur_off_next;
      cur_seen           <= cur_seen_next;
      after_off          <= after_next;
      after_seen         <= after_seen_next;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stream_clear) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream_clear) begin
      out_item <= result;
    end
  end

endmodule
